FILE: hdl/gmfe_pkg.sv
`timescale 1ns / 1ps

package gmfe_pkg;

   // Coordinate and arithmetic widths (Q7.16 in, 2^-32 m^2 squared lengths)
   localparam int COORD_W    = 24;
   localparam int DIFF_W     = COORD_W + 1;
   localparam int SQ_W       = 2 * DIFF_W;
   localparam int SUM_W      = SQ_W + 2;
   localparam int LIMIT_W    = 48;
   localparam int WIDTH_W    = 11;
   localparam int MIN_WIDTH  = 2;

   // Register port
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 48;
   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_WIDTH = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_EDGE_LIMIT  = 1'd1;
   localparam logic [WIDTH_W-1:0]   WIDTH_RESET     = 11'd640;
   localparam logic [LIMIT_W-1:0]   LIMIT_RESET     = 48'd429497;

   // Face queue
   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_PTR_W = 2;
   localparam int FIFO_CNT_W = 3;

   typedef struct packed {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic signed [COORD_W-1:0] z;
   } point_type;

   // Per-pixel control that enters the edge pipeline
   typedef struct packed {
      logic live;
      logic elig;
      logic vk;
      logic vd;
   } pix_tag_type;

   // Triangle verdicts leaving the edge pipeline
   typedef struct packed {
      logic up;
      logic lo;
   } pass_type;

endpackage

FILE: hdl/gmfe_line_store.sv
`timescale 1ns / 1ps

module gmfe_line_store #(
   parameter int DEPTH = 1025,
   parameter int AW    = 11,
   parameter int IW    = 20
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [AW-1:0]       wr_addr,
   input  gmfe_pkg::point_type wr_point,
   input  logic                wr_valid,
   input  logic [IW-1:0]       wr_index,
   input  logic                rd_en,
   input  logic [AW-1:0]       rd_addr_a,
   input  logic [AW-1:0]       rd_addr_b,
   output gmfe_pkg::point_type rd_point_a,
   output logic                rd_valid_a,
   output logic [IW-1:0]       rd_index_a,
   output gmfe_pkg::point_type rd_point_b,
   output logic                rd_valid_b,
   output logic [IW-1:0]       rd_index_b
);

   localparam int PW = $bits(gmfe_pkg::point_type);
   localparam int EW = PW + 1 + IW;

   logic [EW-1:0] store_mem [DEPTH];
   logic [EW-1:0] rd_a_ff;
   logic [EW-1:0] rd_b_ff;

   // One write, two registered reads; reads return the old entry on a collision
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[wr_addr] <= {wr_point, wr_valid, wr_index};
      end
      if (rd_en) begin
         rd_a_ff <= store_mem[rd_addr_a];
         rd_b_ff <= store_mem[rd_addr_b];
      end
   end

   assign rd_point_a = rd_a_ff[EW-1 -: PW];
   assign rd_valid_a = rd_a_ff[IW];
   assign rd_index_a = rd_a_ff[IW-1:0];
   assign rd_point_b = rd_b_ff[EW-1 -: PW];
   assign rd_valid_b = rd_b_ff[IW];
   assign rd_index_b = rd_b_ff[IW-1:0];

endmodule

FILE: hdl/gmfe_edge_check.sv
`timescale 1ns / 1ps

module gmfe_edge_check #(
   parameter int IW = 20
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                adv,
   input  gmfe_pkg::pix_tag_type               tag,
   input  gmfe_pkg::point_type                 pt_i,
   input  gmfe_pkg::point_type                 pt_r,
   input  gmfe_pkg::point_type                 pt_d,
   input  gmfe_pkg::point_type                 pt_k,
   input  logic                                v_i,
   input  logic                                v_r,
   input  logic [IW-1:0]                       idx_i,
   input  logic [IW-1:0]                       idx_r,
   input  logic [IW-1:0]                       idx_d,
   input  logic [IW-1:0]                       idx_k,
   input  logic [gmfe_pkg::LIMIT_W-1:0]        limit,
   output gmfe_pkg::pass_type                  pass,
   output logic [IW-1:0]                       out_idx_i,
   output logic [IW-1:0]                       out_idx_r,
   output logic [IW-1:0]                       out_idx_d,
   output logic [IW-1:0]                       out_idx_k
);

   localparam int NUM_EDGES = 5;
   localparam int NUM_AXES  = 3;
   localparam int EDGE_IR   = 0;
   localparam int EDGE_IK   = 1;
   localparam int EDGE_KR   = 2;
   localparam int EDGE_ID   = 3;
   localparam int EDGE_KD   = 4;
   localparam int DIFF_W    = gmfe_pkg::DIFF_W;
   localparam int SQ_W      = gmfe_pkg::SQ_W;
   localparam int SUM_W     = gmfe_pkg::SUM_W;

   typedef struct packed {
      logic live;
      logic up_ok;
      logic lo_ok;
   } edge_tag_type;

   edge_tag_type                  flag2_in, flag2_ff, flag3_ff, flag4_ff;
   logic [3:0][IW-1:0]            idx1, idx2_ff, idx3_ff, idx4_ff;
   gmfe_pkg::point_type           end_a [NUM_EDGES];
   gmfe_pkg::point_type           end_b [NUM_EDGES];
   logic signed [DIFF_W-1:0]      diff_in [NUM_EDGES][NUM_AXES];
   logic signed [DIFF_W-1:0]      diff_ff [NUM_EDGES][NUM_AXES];
   logic signed [SQ_W-1:0]        prod_in [NUM_EDGES][NUM_AXES];
   logic [SQ_W-1:0]               sq_ff   [NUM_EDGES][NUM_AXES];
   logic [SUM_W-1:0]              sum_in  [NUM_EDGES];
   logic [SUM_W-1:0]              sum_ff  [NUM_EDGES];
   logic [NUM_EDGES-1:0]          edge_ok;

   // Edge endpoints: upper uses (i, r, k), lower uses (i, d, k)
   always_comb begin
      end_a[EDGE_IR] = pt_i;  end_b[EDGE_IR] = pt_r;
      end_a[EDGE_IK] = pt_i;  end_b[EDGE_IK] = pt_k;
      end_a[EDGE_KR] = pt_k;  end_b[EDGE_KR] = pt_r;
      end_a[EDGE_ID] = pt_i;  end_b[EDGE_ID] = pt_d;
      end_a[EDGE_KD] = pt_k;  end_b[EDGE_KD] = pt_d;
   end

   // Stage 2: coordinate differences
   always_comb begin
      for (int e = 0; e < NUM_EDGES; e++) begin
         diff_in[e][0] = DIFF_W'(end_a[e].x) - DIFF_W'(end_b[e].x);
         diff_in[e][1] = DIFF_W'(end_a[e].y) - DIFF_W'(end_b[e].y);
         diff_in[e][2] = DIFF_W'(end_a[e].z) - DIFF_W'(end_b[e].z);
      end
   end

   assign flag2_in.live  = tag.live;
   assign flag2_in.up_ok = tag.elig & tag.vk & v_i & v_r;
   assign flag2_in.lo_ok = tag.elig & tag.vk & v_i & tag.vd;
   assign idx1 = {idx_i, idx_r, idx_d, idx_k};

   // Stage 3: squares, one multiplier per axis per edge
   always_comb begin
      for (int e = 0; e < NUM_EDGES; e++) begin
         for (int a = 0; a < NUM_AXES; a++) begin
            prod_in[e][a] = diff_ff[e][a] * diff_ff[e][a];
         end
      end
   end

   // Stage 4: squared edge lengths
   always_comb begin
      for (int e = 0; e < NUM_EDGES; e++) begin
         sum_in[e] = SUM_W'(sq_ff[e][0]) + SUM_W'(sq_ff[e][1]) + SUM_W'(sq_ff[e][2]);
      end
   end

   // Control flags
   always_ff @(posedge clock) begin
      if (reset) begin
         flag2_ff <= '0;
         flag3_ff <= '0;
         flag4_ff <= '0;
      end else if (adv) begin
         flag2_ff <= flag2_in;
         flag3_ff <= flag2_ff;
         flag4_ff <= flag3_ff;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      if (adv) begin
         idx2_ff <= idx1;
         idx3_ff <= idx2_ff;
         idx4_ff <= idx3_ff;
         for (int e = 0; e < NUM_EDGES; e++) begin
            sum_ff[e] <= sum_in[e];
            for (int a = 0; a < NUM_AXES; a++) begin
               diff_ff[e][a] <= diff_in[e][a];
               sq_ff[e][a]   <= SQ_W'(prod_in[e][a]);
            end
         end
      end
   end

   // Threshold compare on the stage-4 lengths
   always_comb begin
      for (int e = 0; e < NUM_EDGES; e++) begin
         edge_ok[e] = sum_ff[e] <= SUM_W'(limit);
      end
   end

   assign pass.up = flag4_ff.live & flag4_ff.up_ok
                    & edge_ok[EDGE_IR] & edge_ok[EDGE_IK] & edge_ok[EDGE_KR];
   assign pass.lo = flag4_ff.live & flag4_ff.lo_ok
                    & edge_ok[EDGE_ID] & edge_ok[EDGE_IK] & edge_ok[EDGE_KD];

   assign out_idx_i = idx4_ff[3];
   assign out_idx_r = idx4_ff[2];
   assign out_idx_d = idx4_ff[1];
   assign out_idx_k = idx4_ff[0];

endmodule

FILE: hdl/gmfe_face_fifo.sv
`timescale 1ns / 1ps

module gmfe_face_fifo #(
   parameter int FACE_W = 61
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [1:0]                      push_cnt,
   input  logic [FACE_W-1:0]               push_a,
   input  logic [FACE_W-1:0]               push_b,
   input  logic                            pop,
   output logic [FACE_W-1:0]               head,
   output logic                            not_empty,
   output logic [gmfe_pkg::FIFO_CNT_W-1:0] count
);

   localparam int PTR_W = gmfe_pkg::FIFO_PTR_W;
   localparam int CNT_W = gmfe_pkg::FIFO_CNT_W;

   logic [FACE_W-1:0] entry_ff [gmfe_pkg::FIFO_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   // Pointer and occupancy update; up to two pushes and one pop per cycle
   always_comb begin
      wr_ptr_in = wr_ptr_ff + PTR_W'(push_cnt);
      rd_ptr_in = rd_ptr_ff + PTR_W'(pop);
      count_in  = count_ff + CNT_W'(push_cnt) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Face storage
   always_ff @(posedge clock) begin
      if (push_cnt != 2'd0) begin
         entry_ff[wr_ptr_ff] <= push_a;
      end
      if (push_cnt == 2'd2) begin
         entry_ff[wr_ptr_ff + PTR_W'(1)] <= push_b;
      end
   end

   assign head      = entry_ff[rd_ptr_ff];
   assign not_empty = count_ff != '0;
   assign count     = count_ff;

endmodule

FILE: hdl/grid_mesh_face_extractor.sv
`timescale 1ns / 1ps

// Triangle face extractor for a raster-order vertex grid.
//
// Request channel (req_*): one vertex per request, valid/stall handshake.
// req_frame_start restarts pixel indexing. Vertices are written to a line
// store of MAX_ROW+1 entries; pixel k reads pixels k-W and k-W-1 from it and
// keeps pixel k-1 in a register, then tests the upper triangle (i, i+1, k)
// and the lower triangle (i, i+W, k) against the squared edge limit.
// Response channel (rsp_*): one face per response, upper before lower,
// rsp_is_last marks the last face of a pixel. Pixels yielding no face emit nothing.
// Register port (csr_*): index 0 image width, index 1 squared edge limit; always
// ready; the user must see that they are written only while the block is idle.
// The block does not enforce this. Throughput: one request per cycle while
// req_stall is low; one face per cycle leaves the block while rsp_stall is
// low, so pixels that all yield two faces fill the queue and raise req_stall.
// Path: dual-read line store, difference, square and sum stages, then face queue.
// Receiver stall: faces back up in a 4-entry queue; req_stall rises whenever
// fewer than two queue slots are free, which freezes the whole pipeline.
// Reset: counters and pointers clear, registers take 640 and 429497. Line
// store contents stay undefined and need no clearing pass.

module grid_mesh_face_extractor #(
   parameter int MAX_ROW    = 1024,
   parameter int MAX_PIXELS = 1048576,
   localparam int IW        = $clog2(MAX_PIXELS)
) (
   input  logic                                   clock,
   input  logic                                   reset,
   // request channel
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic                                   req_frame_start,
   input  logic                                   req_point_valid,
   input  logic signed [gmfe_pkg::COORD_W-1:0]    req_pos_x,
   input  logic signed [gmfe_pkg::COORD_W-1:0]    req_pos_y,
   input  logic signed [gmfe_pkg::COORD_W-1:0]    req_pos_z,
   // response channel
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic [IW-1:0]                          rsp_corner_a,
   output logic [IW-1:0]                          rsp_corner_b,
   output logic [IW-1:0]                          rsp_corner_c,
   output logic                                   rsp_is_last,
   // register port
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [gmfe_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [gmfe_pkg::CSR_DATA_W-1:0]        csr_data
);

   localparam int DEPTH  = MAX_ROW + 1;
   localparam int AW     = $clog2(DEPTH);
   localparam int FW     = $clog2(DEPTH + 1);
   localparam int FACE_W = 3 * IW + 1;

   // Configuration registers
   logic [gmfe_pkg::WIDTH_W-1:0] image_width_ff;
   logic [gmfe_pkg::LIMIT_W-1:0] edge_limit_ff;

   // Frame counters
   logic [IW-1:0] pixel_cnt_ff, pixel_cnt_in, pixel_eff;
   logic [AW-1:0] col_cnt_ff, col_cnt_in, col_eff;
   logic [AW:0]   col_p1;
   logic [FW-1:0] fill_cnt_ff, fill_cnt_in, fill_eff;
   logic [AW-1:0] wr_ptr_ff, wr_ptr_in;

   logic [AW-1:0] w;
   logic [AW:0]   w_ext, w_p1, back_w, back_w1;
   logic [AW-1:0] rd_addr_r, rd_addr_i;
   logic          elig;
   logic          adv, accept, pop;

   // Previous pixel and stage-1 registers
   gmfe_pkg::point_type   req_pt;
   gmfe_pkg::point_type   last_pt_ff, pt_k1_ff, pt_d1_ff;
   logic                  last_v_ff;
   logic [IW-1:0]         last_idx_ff, idx_k1_ff, idx_d1_ff;
   gmfe_pkg::pix_tag_type tag1_ff, tag1_in;

   // Line store read data
   gmfe_pkg::point_type   pt_i1, pt_r1;
   logic                  v_i1, v_r1;
   logic [IW-1:0]         idx_i1, idx_r1;

   // Edge pipeline outputs and face queue
   gmfe_pkg::pass_type                  pass;
   logic [IW-1:0]                       f_idx_i, f_idx_r, f_idx_d, f_idx_k;
   logic [1:0]                          push_cnt;
   logic [FACE_W-1:0]                   face_up, face_lo, push_a;
   logic [FACE_W-1:0]                   head;
   logic [gmfe_pkg::FIFO_CNT_W-1:0]     fifo_count;

   // Register writes
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff <= gmfe_pkg::WIDTH_RESET;
         edge_limit_ff  <= gmfe_pkg::LIMIT_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            gmfe_pkg::REG_IMAGE_WIDTH: begin
               image_width_ff <= csr_data[gmfe_pkg::WIDTH_W-1:0];
            end
            gmfe_pkg::REG_EDGE_LIMIT: begin
               edge_limit_ff <= csr_data[gmfe_pkg::LIMIT_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // Effective width, clamped to [2, MAX_ROW]
   always_comb begin
      if (32'(image_width_ff) > MAX_ROW) begin
         w = AW'(MAX_ROW);
      end else if (32'(image_width_ff) < gmfe_pkg::MIN_WIDTH) begin
         w = AW'(gmfe_pkg::MIN_WIDTH);
      end else begin
         w = AW'(image_width_ff);
      end
   end

   // Pipeline moves while the face queue has room for two faces
   assign adv       = 32'(fifo_count) <= gmfe_pkg::FIFO_DEPTH - 2;
   assign req_stall = !adv;
   assign accept    = req_valid && adv;
   assign pop       = rsp_valid && !rsp_stall;

   // Counter next values, frame start restarts counting
   always_comb begin
      pixel_eff = req_frame_start ? '0 : pixel_cnt_ff;
      col_eff   = req_frame_start ? '0 : col_cnt_ff;
      fill_eff  = req_frame_start ? '0 : fill_cnt_ff;

      pixel_cnt_in = (pixel_eff == IW'(MAX_PIXELS - 1)) ? '0 : pixel_eff + 1'b1;
      col_p1       = {1'b0, col_eff} + 1'b1;
      col_cnt_in   = (col_p1 >= {1'b0, w}) ? '0 : col_p1[AW-1:0];
      fill_cnt_in  = (32'(fill_eff) < DEPTH) ? fill_eff + 1'b1 : fill_eff;
      wr_ptr_in    = (32'(wr_ptr_ff) == DEPTH - 1) ? '0 : wr_ptr_ff + 1'b1;

      elig = (32'(fill_eff) >= 32'(w) + 1) && (col_eff != '0);
   end

   // Store addresses W and W+1 entries back, modulo the store depth
   always_comb begin
      w_ext   = {1'b0, w};
      w_p1    = w_ext + 1'b1;
      back_w  = {1'b0, wr_ptr_ff} - w_ext;
      back_w1 = {1'b0, wr_ptr_ff} - w_p1;
      rd_addr_r = back_w[AW]  ? AW'(back_w  + (AW+1)'(DEPTH)) : back_w[AW-1:0];
      rd_addr_i = back_w1[AW] ? AW'(back_w1 + (AW+1)'(DEPTH)) : back_w1[AW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pixel_cnt_ff <= '0;
         col_cnt_ff   <= '0;
         fill_cnt_ff  <= '0;
         wr_ptr_ff    <= '0;
      end else if (accept) begin
         pixel_cnt_ff <= pixel_cnt_in;
         col_cnt_ff   <= col_cnt_in;
         fill_cnt_ff  <= fill_cnt_in;
         wr_ptr_ff    <= wr_ptr_in;
      end
   end

   assign req_pt.x = req_pos_x;
   assign req_pt.y = req_pos_y;
   assign req_pt.z = req_pos_z;

   // Stage 1 control
   always_comb begin
      tag1_in.live = accept;
      tag1_in.elig = elig;
      tag1_in.vk   = req_point_valid;
      tag1_in.vd   = last_v_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag1_ff <= '0;
      end else if (adv) begin
         tag1_ff <= tag1_in;
      end
   end

   // Stage 1 payload and the previous pixel
   always_ff @(posedge clock) begin
      if (accept) begin
         pt_k1_ff    <= req_pt;
         pt_d1_ff    <= last_pt_ff;
         idx_k1_ff   <= pixel_eff;
         idx_d1_ff   <= last_idx_ff;
         last_pt_ff  <= req_pt;
         last_v_ff   <= req_point_valid;
         last_idx_ff <= pixel_eff;
      end
   end

   gmfe_line_store #(
      .DEPTH (DEPTH),
      .AW    (AW),
      .IW    (IW)
   ) u_store (
      .clock      (clock),
      .wr_en      (accept),
      .wr_addr    (wr_ptr_ff),
      .wr_point   (req_pt),
      .wr_valid   (req_point_valid),
      .wr_index   (pixel_eff),
      .rd_en      (accept),
      .rd_addr_a  (rd_addr_i),
      .rd_addr_b  (rd_addr_r),
      .rd_point_a (pt_i1),
      .rd_valid_a (v_i1),
      .rd_index_a (idx_i1),
      .rd_point_b (pt_r1),
      .rd_valid_b (v_r1),
      .rd_index_b (idx_r1)
   );

   gmfe_edge_check #(
      .IW (IW)
   ) u_edge (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .tag       (tag1_ff),
      .pt_i      (pt_i1),
      .pt_r      (pt_r1),
      .pt_d      (pt_d1_ff),
      .pt_k      (pt_k1_ff),
      .v_i       (v_i1),
      .v_r       (v_r1),
      .idx_i     (idx_i1),
      .idx_r     (idx_r1),
      .idx_d     (idx_d1_ff),
      .idx_k     (idx_k1_ff),
      .limit     (edge_limit_ff),
      .pass      (pass),
      .out_idx_i (f_idx_i),
      .out_idx_r (f_idx_r),
      .out_idx_d (f_idx_d),
      .out_idx_k (f_idx_k)
   );

   // Face assembly: upper first, last flag on the final face of the pixel
   always_comb begin
      face_up  = {f_idx_i, f_idx_r, f_idx_k, !pass.lo};
      face_lo  = {f_idx_i, f_idx_d, f_idx_k, 1'b1};
      push_a   = pass.up ? face_up : face_lo;
      push_cnt = adv ? ({1'b0, pass.up} + {1'b0, pass.lo}) : 2'd0;
   end

   gmfe_face_fifo #(
      .FACE_W (FACE_W)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push_cnt  (push_cnt),
      .push_a    (push_a),
      .push_b    (face_lo),
      .pop       (pop),
      .head      (head),
      .not_empty (rsp_valid),
      .count     (fifo_count)
   );

   assign rsp_corner_a = head[FACE_W-1 -: IW];
   assign rsp_corner_b = head[2*IW -: IW];
   assign rsp_corner_c = head[IW:1];
   assign rsp_is_last  = head[0];

`ifndef SYNTHESIS
   a_fifo_bound: assert property (@(posedge clock) disable iff (reset)
      32'(fifo_count) <= gmfe_pkg::FIFO_DEPTH)
      else $error("face queue overflow");

   a_wr_ptr_range: assert property (@(posedge clock) disable iff (reset)
      32'(wr_ptr_ff) < DEPTH)
      else $error("line store write pointer out of range");

   a_fill_range: assert property (@(posedge clock) disable iff (reset)
      32'(fill_cnt_ff) <= DEPTH)
      else $error("fill count beyond store depth");

   a_push_shows: assert property (@(posedge clock) disable iff (reset)
      (push_cnt != 2'd0) |=> rsp_valid)
      else $error("pushed face not presented");
`endif

endmodule
